/* rtl/vpsb_pkg.sv */
// shared types, command codes and saturating add for the path segment builder
package vpsb_pkg;

  localparam int CoordW = 32;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_REPEAT = 3'd0;
  localparam cmd_t CMD_MOVE   = 3'd1;
  localparam cmd_t CMD_LINE   = 3'd2;
  localparam cmd_t CMD_HORIZ  = 3'd3;
  localparam cmd_t CMD_VERT   = 3'd4;
  localparam cmd_t CMD_CLOSE  = 3'd5;

  localparam logic [7:0] REG_ORIGIN_X = 8'd0;
  localparam logic [7:0] REG_ORIGIN_Y = 8'd1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_PREV = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  // pen state carried from one command to the next
  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t first_x;
    coord_t first_y;
    logic   have_first;
    cmd_t   prev_cmd;
    logic   prev_rel;
  } pen_t;

  // one result item
  typedef struct packed {
    logic   status;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_t;

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic signed [CoordW:0] s;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    if (s[CoordW] != s[CoordW-1]) begin
      return s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
    return s[CoordW-1:0];
  endfunction

endpackage

/* rtl/vpsb_step.sv */
// combinational step: one path command against the pen state
module vpsb_step (
  input  vpsb_pkg::pen_t   pen,
  input  vpsb_pkg::coord_t origin_x,
  input  vpsb_pkg::coord_t origin_y,
  input  vpsb_pkg::cmd_t   command,
  input  logic             relative,
  input  vpsb_pkg::coord_t coord_x,
  input  vpsb_pkg::coord_t coord_y,
  output vpsb_pkg::pen_t   pen_next,
  output logic             emit,
  output vpsb_pkg::seg_t   seg
);
  import vpsb_pkg::*;

  logic   is_repeat;
  logic   no_prev;
  cmd_t   cmd_eff;
  logic   rel_eff;
  coord_t sum_x;
  coord_t sum_y;
  coord_t end_x;
  coord_t end_y;

  assign is_repeat = (command == CMD_REPEAT) || (command > CMD_CLOSE);
  assign no_prev   = (pen.prev_cmd == CMD_REPEAT) || (pen.prev_cmd >= CMD_CLOSE);

  always_comb begin
    cmd_eff = command;
    rel_eff = relative;
    if (is_repeat) begin
      // replayed move draws a line
      cmd_eff = (pen.prev_cmd == CMD_MOVE) ? CMD_LINE : pen.prev_cmd;
      rel_eff = pen.prev_rel;
    end
  end

  // one adder per axis: relative to the pen or offset by the origin
  assign sum_x = sat_add(rel_eff ? pen.point_x : origin_x, coord_x);
  assign sum_y = sat_add(rel_eff ? pen.point_y : origin_y, coord_y);

  always_comb begin
    case (cmd_eff)
      CMD_LINE: begin
        end_x = sum_x;
        end_y = sum_y;
      end
      CMD_HORIZ: begin
        end_x = sum_x;
        end_y = pen.point_y;
      end
      CMD_VERT: begin
        end_x = pen.point_x;
        end_y = sum_y;
      end
      default: begin
        end_x = pen.have_first ? pen.first_x : pen.point_x;
        end_y = pen.have_first ? pen.first_y : pen.point_y;
      end
    endcase
  end

  always_comb begin
    pen_next = pen;
    emit     = 1'b1;
    seg      = '0;
    if (is_repeat && no_prev) begin
      seg.status = STATUS_NO_PREV;
    end else begin
      pen_next.prev_cmd = cmd_eff;
      pen_next.prev_rel = rel_eff;
      if (cmd_eff == CMD_MOVE) begin
        emit             = 1'b0;
        pen_next.point_x = sum_x;
        pen_next.point_y = sum_y;
      end else begin
        seg.status       = STATUS_OK;
        seg.start_x      = pen.point_x;
        seg.start_y      = pen.point_y;
        seg.end_x        = end_x;
        seg.end_y        = end_y;
        pen_next.point_x = end_x;
        pen_next.point_y = end_y;
        if (!pen.have_first) begin
          pen_next.first_x    = pen.point_x;
          pen_next.first_y    = pen.point_y;
          pen_next.have_first = 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/vector_path_segment_builder_core.sv */
// top level of the path segment builder: handshakes, state and result registers
//
// turns tokenised path commands into straight line segments in Q16.16
// input stream: s_tuser carries command and relative flag, s_tdata the two
//   coordinates; one command is taken per transfer
// output stream: one transfer per line, horizontal, vertical or close command,
//   and one transfer with status set for a repeat token with nothing to repeat;
//   move commands update the pen and give no transfer
// config channel: cfg_index 0 writes origin_x, 1 writes origin_y, other
//   indexes are ignored; always ready, affects only commands evaluated after the write
// path: each command is captured in the input register, its segment is computed
//   from it and registered in the output register
// throughput: one command per cycle while the output is not stalled, set by the
//   single evaluation stage that reads and updates the pen state in the same cycle
// stall: the output register holds its segment while m_tready is low; the
//   input register then holds one command and s_tready drops, except that a
//   pending move still retires since it needs no output slot
// reset (rst, synchronous): pen at 0,0, no first segment, no previous
//   command, origin 0,0, both registers empty
module vector_path_segment_builder_core (
  input  logic         clk,
  input  logic         rst,
  // slave stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,    // [31:0] coord_x, [63:32] coord_y
  input  logic [3:0]   s_tuser,    // [2:0] command, [3] relative
  // master stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,    // seg_start_x, seg_start_y, seg_end_x, seg_end_y
  output logic [0:0]   m_tuser,    // [0] status
  // config write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import vpsb_pkg::*;

  // origin registers
  coord_t origin_x;
  coord_t origin_y;

  // input register
  logic   in_valid;
  cmd_t   in_cmd;
  logic   in_rel;
  coord_t in_x;
  coord_t in_y;

  // pen state
  pen_t   pen;
  pen_t   pen_next;

  // step result
  logic   emit;
  seg_t   seg;

  // output register
  logic   out_valid;
  seg_t   out_seg;

  logic   fire;
  logic   out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        default: ;
      endcase
    end
  end

  vpsb_step u_step (
    .pen      (pen),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .command  (in_cmd),
    .relative (in_rel),
    .coord_x  (in_x),
    .coord_y  (in_y),
    .pen_next (pen_next),
    .emit     (emit),
    .seg      (seg)
  );

  // the held command retires when its result has a place to go or it gives no result
  assign out_free = !out_valid || m_tready;
  assign fire     = in_valid && (out_free || !emit);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tuser[2:0];
      in_rel <= s_tuser[3];
      in_x   <= s_tdata[31:0];
      in_y   <= s_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen <= '0;
    end else if (fire) begin
      pen <= pen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_seg <= seg;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_seg.status;
  assign m_tdata  = {out_seg.end_y, out_seg.end_x, out_seg.start_y, out_seg.start_x};

  // once a segment has been drawn the first start stays known
  a_have_first_sticks: assert property (@(posedge clk) disable iff (rst)
    pen.have_first |=> pen.have_first)
    else $error("first segment flag cleared");

  // a retired move or segment never leaves a repeat code behind
  a_prev_not_repeat: assert property (@(posedge clk) disable iff (rst)
    fire && seg.status == STATUS_OK |=> pen.prev_cmd != CMD_REPEAT)
    else $error("repeat code stored as previous command");

  // an error result carries zero coordinates
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_seg.status == STATUS_NO_PREV |->
      out_seg.start_x == '0 && out_seg.start_y == '0 &&
      out_seg.end_x == '0 && out_seg.end_y == '0)
    else $error("error result with nonzero coordinates");

  // a held command only waits on a stalled output
  a_hold_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |-> out_valid && !m_tready)
    else $error("input register stuck without output stall");

  // an error result never moves the pen
  a_error_keeps_pen: assert property (@(posedge clk) disable iff (rst)
    fire && emit && seg.status == STATUS_NO_PREV |=> $stable(pen))
    else $error("pen changed on error result");

endmodule

/* test/tb_vector_path_segment_builder_core.sv */
// testbench for the path segment builder core: directed probes, then randomized command streams
`timescale 1ns / 1ps

module tb_vector_path_segment_builder_core;
  import vpsb_pkg::*;

  // slack after the last expected segment: input register, evaluation, output register
  localparam int SettleCycles = 8;
  // bound on waiting for outstanding segments to drain
  localparam int DrainLimit = 5000;
  // at most this many mismatch lines are printed, all are counted
  localparam int PrintLimit = 30;
  localparam int PhaseItems = 330;
  localparam longint CoordMax = 2147483647;
  localparam longint CoordMin = -CoordMax - 1;

  localparam coord_t C_MAX = 32'sh7fffffff;
  localparam coord_t C_MIN = 32'sh80000000;
  localparam coord_t C_ONE = 32'sh00010000;

  // canned results for rows that can be read off directly
  localparam seg_t NoPrevSeg = {STATUS_NO_PREV, 128'd0};
  localparam seg_t ZeroSeg   = {STATUS_OK, 128'd0};
  localparam seg_t PinnedSeg = {STATUS_OK, C_MAX, C_MIN, C_MAX, C_MIN};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b1;
  logic [127:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  vector_path_segment_builder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // pen tracker: mirrors the block's state and predicts each segment
  // ---------------------------------------------------------------------------
  pen_t   pen_model;
  coord_t shadow_origin_x;
  coord_t shadow_origin_y;

  // segments still owed by the block, oldest first
  seg_t pending_segments[$];
  int   mismatch_count = 0;
  // random stalls on both sides while set
  logic idling_on = 1'b0;

  function automatic coord_t clamp_sum(input coord_t a, input coord_t b);
    longint total;
    total = longint'(a) + longint'(b);
    if (total > CoordMax) return C_MAX;
    if (total < CoordMin) return C_MIN;
    return coord_t'(total);
  endfunction

  // advances the tracked pen by one command; returns 1 when a segment is owed
  function automatic logic plan_segment(input cmd_t cmd_in, input logic rel_in,
                                        input coord_t x, input coord_t y,
                                        output seg_t seg);
    cmd_t   cmd;
    logic   rel;
    coord_t end_x;
    coord_t end_y;
    cmd = cmd_in;
    rel = rel_in;
    seg = '0;
    // repeat token, codes above close count as repeat too
    if (cmd == CMD_REPEAT || cmd > CMD_CLOSE) begin
      if (pen_model.prev_cmd == CMD_REPEAT || pen_model.prev_cmd >= CMD_CLOSE) begin
        // nothing usable to replay: error result, pen untouched
        seg.status = STATUS_NO_PREV;
        return 1'b1;
      end
      cmd = (pen_model.prev_cmd == CMD_MOVE) ? CMD_LINE : pen_model.prev_cmd;
      rel = pen_model.prev_rel;
    end
    pen_model.prev_cmd = cmd;
    pen_model.prev_rel = rel;

    if (cmd == CMD_MOVE) begin
      pen_model.point_x = clamp_sum(rel ? pen_model.point_x : shadow_origin_x, x);
      pen_model.point_y = clamp_sum(rel ? pen_model.point_y : shadow_origin_y, y);
      return 1'b0;
    end

    case (cmd)
      CMD_LINE: begin
        end_x = clamp_sum(rel ? pen_model.point_x : shadow_origin_x, x);
        end_y = clamp_sum(rel ? pen_model.point_y : shadow_origin_y, y);
      end
      CMD_HORIZ: begin
        end_x = clamp_sum(rel ? pen_model.point_x : shadow_origin_x, x);
        end_y = pen_model.point_y;
      end
      CMD_VERT: begin
        end_x = pen_model.point_x;
        end_y = clamp_sum(rel ? pen_model.point_y : shadow_origin_y, y);
      end
      default: begin
        // close: back to where the first segment began, or stay put if none yet
        end_x = pen_model.have_first ? pen_model.first_x : pen_model.point_x;
        end_y = pen_model.have_first ? pen_model.first_y : pen_model.point_y;
      end
    endcase

    if (!pen_model.have_first) begin
      pen_model.first_x    = pen_model.point_x;
      pen_model.first_y    = pen_model.point_y;
      pen_model.have_first = 1'b1;
    end

    seg.status  = STATUS_OK;
    seg.start_x = pen_model.point_x;
    seg.start_y = pen_model.point_y;
    seg.end_x   = end_x;
    seg.end_y   = end_y;
    pen_model.point_x = end_x;
    pen_model.point_y = end_y;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintLimit) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random ready stalls in bursts
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst || !idling_on) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker: every output transfer is matched against the oldest owed segment
  always @(posedge clk) begin
    seg_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_segments.size() == 0) begin
        report_mismatch($sformatf("segment with nothing owed, status %0d data %h",
                                  m_tuser[0], m_tdata));
      end else begin
        want = pending_segments.pop_front();
        if (m_tuser[0] !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", m_tuser[0], want.status));
        if (m_tdata[31:0] !== want.start_x)
          report_mismatch($sformatf("start_x got %h want %h", m_tdata[31:0], want.start_x));
        if (m_tdata[63:32] !== want.start_y)
          report_mismatch($sformatf("start_y got %h want %h", m_tdata[63:32], want.start_y));
        if (m_tdata[95:64] !== want.end_x)
          report_mismatch($sformatf("end_x got %h want %h", m_tdata[95:64], want.end_x));
        if (m_tdata[127:96] !== want.end_y)
          report_mismatch($sformatf("end_y got %h want %h", m_tdata[127:96], want.end_y));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one command transfer; the owed segment is either the tracker's or a typed one
  task automatic send_command(input cmd_t cmd, input logic rel, input coord_t x,
                              input coord_t y, input logic typed, input seg_t typed_seg);
    seg_t predicted;
    logic owed;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {rel, cmd};
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    owed = plan_segment(cmd, rel, x, y, predicted);
    if (owed) pending_segments.push_back(typed ? typed_seg : predicted);
  endtask

  // stop sending and wait out every owed segment plus the pipeline tail
  task automatic drain_and_settle();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (pending_segments.size() != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    if (pending_segments.size() != 0) begin
      report_mismatch($sformatf("%0d segments never arrived", pending_segments.size()));
      pending_segments.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // both origin registers, only called while the block is idle
  task automatic set_origin(input coord_t ox, input coord_t oy);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= ox;
    do @(posedge clk); while (!cfg_ready);
    shadow_origin_x = ox;
    cfg_index <= REG_ORIGIN_Y;
    cfg_data  <= oy;
    do @(posedge clk); while (!cfg_ready);
    shadow_origin_y = oy;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // coordinates lean on extremes and small Q16.16 values, plus full-range noise
  function automatic coord_t pick_coord();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3, 4, 5: return coord_t'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      default: return coord_t'($urandom());
    endcase
  endfunction

  // mostly real path shapes; a close is usually followed by a fresh move
  function automatic cmd_t pick_command(input cmd_t last);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (last == CMD_CLOSE && roll < 80) return CMD_MOVE;
    if (roll < 15) return CMD_MOVE;
    if (roll < 40) return CMD_LINE;
    if (roll < 52) return CMD_HORIZ;
    if (roll < 64) return CMD_VERT;
    if (roll < 72) return CMD_CLOSE;
    if (roll < 96) return CMD_REPEAT;
    return cmd_t'($urandom_range(6, 7));
  endfunction

  // ---------------------------------------------------------------------------
  // directed probes
  // ---------------------------------------------------------------------------
  typedef struct {
    cmd_t   cmd;
    logic   rel;
    coord_t x;
    coord_t y;
    logic   typed;
    seg_t   want;
  } probe_t;

  probe_t probes[$];

  function automatic probe_t row(input cmd_t cmd, input logic rel, input coord_t x,
                                 input coord_t y, input logic typed, input seg_t want);
    probe_t p;
    p.cmd = cmd; p.rel = rel; p.x = x; p.y = y; p.typed = typed; p.want = want;
    return p;
  endfunction

  initial begin
    // repeat right after reset: nothing to replay
    probes.push_back(row(CMD_REPEAT, 1'b0, '1, '1, 1'b1, NoPrevSeg));
    probes.push_back(row(cmd_t'(7), 1'b1, C_MAX, C_MIN, 1'b1, NoPrevSeg));
    // close with no segment yet: zero length at the pen, coordinates ignored
    probes.push_back(row(CMD_CLOSE, 1'b1, 32'sh0001_2345, C_MIN, 1'b1, ZeroSeg));
    // repeat after close is an error, also via the spare codes
    probes.push_back(row(CMD_REPEAT, 1'b1, C_ONE, C_ONE, 1'b1, NoPrevSeg));
    probes.push_back(row(cmd_t'(6), 1'b0, '0, '0, 1'b1, NoPrevSeg));
    // pen to the corner, then a relative step that saturates on both axes
    probes.push_back(row(CMD_MOVE, 1'b0, C_MAX, C_MIN, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_LINE, 1'b1, 32'sd1, -32'sd1, 1'b1, PinnedSeg));
    probes.push_back(row(CMD_REPEAT, 1'b0, -C_ONE, C_ONE, 1'b0, ZeroSeg));
    // repeat after move replays as line and keeps the move's relative flag
    probes.push_back(row(CMD_MOVE, 1'b1, C_MIN, C_MAX, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_REPEAT, 1'b0, 32'sh0003_8000, -32'sh0001_4000, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_REPEAT, 1'b0, C_MAX, C_MAX, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_HORIZ, 1'b0, C_MIN, C_MAX, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_HORIZ, 1'b1, C_MAX, C_MIN, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_VERT, 1'b0, C_MIN, C_MAX, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_VERT, 1'b1, C_MAX, C_MIN, 1'b0, ZeroSeg));
    probes.push_back(row(cmd_t'(7), 1'b0, '0, C_ONE, 1'b0, ZeroSeg));
    // close returns to the first segment's start
    probes.push_back(row(CMD_CLOSE, 1'b0, C_MAX, C_MAX, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_LINE, 1'b0, '0, '0, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_LINE, 1'b0, C_MIN, C_MAX, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_MOVE, 1'b0, C_ONE, -C_ONE, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_REPEAT, 1'b1, 32'sh0002_0000, 32'sh0005_0000, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_LINE, 1'b1, '1, 32'sd1, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_CLOSE, 1'b1, '1, '1, 1'b0, ZeroSeg));
    probes.push_back(row(CMD_MOVE, 1'b1, C_MAX, C_MAX, 1'b0, ZeroSeg));
    probes.push_back(row(cmd_t'(6), 1'b0, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, ZeroSeg));
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cmd_t   last_cmd;
    cmd_t   cmd;
    coord_t phase_ox[5];
    coord_t phase_oy[5];

    pen_model       = '0;
    shadow_origin_x = '0;
    shadow_origin_y = '0;
    last_cmd        = CMD_REPEAT;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at origin zero, no stalls so the canned rows stay simple to read
    set_origin('0, '0);
    foreach (probes[i])
      send_command(probes[i].cmd, probes[i].rel, probes[i].x, probes[i].y,
                   probes[i].typed, probes[i].want);
    drain_and_settle();

    // origin settings per phase: both extremes, random, small, back to zero
    phase_ox[0] = C_MAX;                 phase_oy[0] = C_MIN;
    phase_ox[1] = C_MIN;                 phase_oy[1] = C_MAX;
    phase_ox[2] = coord_t'($urandom());  phase_oy[2] = coord_t'($urandom());
    phase_ox[3] = coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    phase_oy[3] = coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    phase_ox[4] = '0;                    phase_oy[4] = '0;

    for (int ph = 0; ph < 5; ph++) begin
      set_origin(phase_ox[ph], phase_oy[ph]);
      // stalls on in the even phases other than the closing phase, which has none at all
      idling_on = (ph % 2 == 0) && (ph != 4);
      for (int n = 0; n < PhaseItems; n++) begin
        cmd = pick_command(last_cmd);
        send_command(cmd, 1'($urandom_range(0, 1)), pick_coord(), pick_coord(), 1'b0,
                     ZeroSeg);
        last_cmd = cmd;
      end
      // sender holds off until everything owed has come back
      drain_and_settle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* vector_path_segment_builder_core.f */
rtl/vpsb_pkg.sv
rtl/vpsb_step.sv
rtl/vector_path_segment_builder_core.sv
test/tb_vector_path_segment_builder_core.sv
